// ----- design/sprr_pkg.sv -----
// ----------------------------------------------------------------------------
// sprr_pkg
// Shared types and codes for the strict priority round robin scheduler.
// ----------------------------------------------------------------------------
package sprr_pkg;

  // Table sizes; the port widths of the top level are built for these.
  localparam int ENTITIES = 16;
  localparam int LEVELS   = 8;

  localparam logic [2:0] KIND_ENQ    = 3'd0;
  localparam logic [2:0] KIND_DEQ    = 3'd1;
  localparam logic [2:0] KIND_PICK   = 3'd2;
  localparam logic [2:0] KIND_CHARGE = 3'd3;
  localparam logic [2:0] KIND_SETPRI = 3'd4;
  localparam logic [2:0] KIND_INIT   = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [31:0] SLICE_DEFAULT = 32'd10000000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input word
    logic analyze;   // evaluate the operation, set result fields
    logic unlink;    // remove the entity from its current level
    logic relevel;   // write the new level
    logic link;      // append the entity at its level tail
    logic finish;    // queue flag, count and slice updates
  } sprr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic do_unlink;
    logic do_relevel;
    logic do_link;
  } sprr_stat_t;

endpackage

// ----- design/sprr_ctrl.sv -----
// ----------------------------------------------------------------------------
// sprr_ctrl
// Sequencer that steps one operation through analyze, unlink, link, finish.
// ----------------------------------------------------------------------------
module sprr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  sprr_pkg::sprr_stat_t stat,
  output sprr_pkg::sprr_cmd_t  cmd
);
  import sprr_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ANA    = 3'd1;
  localparam logic [2:0] S_UNLINK = 3'd2;
  localparam logic [2:0] S_LINK   = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0] state, state_next;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_next = S_ANA;
      end
      S_ANA: begin
        cmd.analyze = 1'b1;
        state_next = S_UNLINK;
      end
      S_UNLINK: begin
        cmd.unlink  = stat.do_unlink;
        cmd.relevel = stat.do_relevel;
        state_next = S_LINK;
      end
      S_LINK: begin
        cmd.link = stat.do_link;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

// ----- design/sprr_dp.sv -----
// ----------------------------------------------------------------------------
// sprr_dp
// Link tables, per-entity slices and levels, and the result registers.
// ----------------------------------------------------------------------------
module sprr_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  sprr_pkg::sprr_cmd_t  cmd,
  output sprr_pkg::sprr_stat_t stat,
  input  logic                 slice_we,
  input  logic [31:0]          slice_wdata,
  input  logic [2:0]           kind,
  input  logic [3:0]           entity,
  input  logic [7:0]           prio_level,
  input  logic [31:0]          runtime_ns,
  output logic [1:0]           status,
  output logic [3:0]           picked_entity,
  output logic [2:0]           picked_level,
  output logic                 slice_expired,
  output logic [4:0]           queued_count
);
  import sprr_pkg::*;

  localparam int EW = (ENTITIES > 1) ? $clog2(ENTITIES) : 1;
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  logic [31:0]   reload;
  logic [LW-1:0] ent_lvl   [ENTITIES];
  logic [31:0]   slice     [ENTITIES];
  logic [ENTITIES-1:0] onq;
  logic [EW-1:0] nxt       [ENTITIES];
  logic [EW-1:0] prv       [ENTITIES];
  logic [EW-1:0] head      [LEVELS];
  logic [EW-1:0] tail      [LEVELS];
  logic [LEVELS-1:0] nonempty;
  logic [4:0]    count;

  // Captured operation.
  logic [2:0]    op_kind;
  logic [3:0]    op_ent;
  logic [7:0]    op_prio;
  logic [31:0]   op_run;
  logic [EW-1:0] e;
  logic          do_unlink, do_relevel, do_link, do_enq, do_deq, do_slice;
  logic [LW-1:0] new_lvl;

  assign e = op_ent[EW-1:0];
  assign stat = '{do_unlink: do_unlink, do_relevel: do_relevel, do_link: do_link};
  assign queued_count = count;

  // Operation decode.
  logic          ent_ok, expire;
  logic [LW-1:0] clamped;
  always_comb begin
    ent_ok  = ({4'd0, op_ent} < 8'(ENTITIES)) && (op_kind <= KIND_INIT);
    expire  = op_run >= slice[e];
    clamped = ({24'd0, op_prio} > 32'(LEVELS - 1)) ? LW'(LEVELS - 1) : op_prio[LW-1:0];
  end

  // Lowest-numbered non-empty level (level 0 wins over higher levels).
  logic          pick_found;
  logic [LW-1:0] pick_lvl;
  always_comb begin
    pick_found = 1'b0;
    pick_lvl = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (nonempty[l]) begin
        pick_found = 1'b1;
        pick_lvl = LW'(l);
      end
    end
  end

  // Unlink fields.
  logic [LW-1:0] ul;
  logic [EW-1:0] up, un;
  logic          is_h, is_t;
  assign ul   = ent_lvl[e];
  assign up   = prv[e];
  assign un   = nxt[e];
  assign is_h = head[ul] == e;
  assign is_t = tail[ul] == e;

  always_ff @(posedge clk) begin
    if (rst) begin
      reload   <= SLICE_DEFAULT;
      onq      <= '0;
      nonempty <= '0;
      count    <= '0;
      for (int i = 0; i < ENTITIES; i++) begin
        ent_lvl[i] <= '0;
        slice[i]   <= '0;
      end
      do_unlink  <= 1'b0;
      do_relevel <= 1'b0;
      do_link    <= 1'b0;
      do_enq     <= 1'b0;
      do_deq     <= 1'b0;
      do_slice   <= 1'b0;
    end else begin
      if (slice_we) reload <= slice_wdata;
      if (cmd.load) begin
        op_kind <= kind;
        op_ent  <= entity;
        op_prio <= prio_level;
        op_run  <= runtime_ns;
      end
      if (cmd.analyze) begin
        do_unlink     <= 1'b0;
        do_relevel    <= 1'b0;
        do_link       <= 1'b0;
        do_enq        <= 1'b0;
        do_deq        <= 1'b0;
        do_slice      <= 1'b0;
        status        <= ST_OK;
        picked_entity <= '0;
        picked_level  <= '0;
        slice_expired <= 1'b0;
        new_lvl       <= clamped;
        if (op_kind == KIND_PICK) begin
          if (pick_found) begin
            picked_entity <= 4'(head[pick_lvl]);
            picked_level  <= 3'(pick_lvl);
          end else begin
            status <= ST_EMPTY;
          end
        end else if (!ent_ok) begin
          status <= ST_INVALID;
        end else begin
          unique case (op_kind)
            KIND_ENQ: begin
              if (onq[e]) status <= ST_INVALID;
              else begin
                do_link <= 1'b1;
                do_enq  <= 1'b1;
              end
            end
            KIND_DEQ: begin
              if (!onq[e]) status <= ST_INVALID;
              else begin
                do_unlink <= 1'b1;
                do_deq    <= 1'b1;
              end
            end
            KIND_CHARGE: begin
              do_slice <= 1'b1;
              if (expire) begin
                slice_expired <= 1'b1;
                do_unlink <= onq[e];
                do_link   <= onq[e];
              end
            end
            KIND_SETPRI: begin
              do_relevel <= 1'b1;
              do_unlink  <= onq[e];
              do_link    <= onq[e];
            end
            KIND_INIT: begin
              if (onq[e]) status <= ST_INVALID;
              else begin
                do_relevel <= 1'b1;
                do_slice   <= 1'b1;
              end
            end
            default: status <= ST_INVALID;
          endcase
        end
      end
      if (cmd.relevel) ent_lvl[e] <= new_lvl;
      if (cmd.unlink) begin
        if (is_h && is_t) nonempty[ul] <= 1'b0;
        else begin
          if (is_h) head[ul] <= un;
          else      nxt[up] <= is_t ? up : un;
          if (is_t) tail[ul] <= up;
          else      prv[un] <= is_h ? un : up;
        end
      end
      if (cmd.link) begin
        if (nonempty[ul]) begin
          nxt[tail[ul]] <= e;
          prv[e] <= tail[ul];
        end else begin
          head[ul] <= e;
          prv[e] <= e;
          nonempty[ul] <= 1'b1;
        end
        nxt[e] <= e;
        tail[ul] <= e;
      end
      if (cmd.finish) begin
        if (do_enq) begin
          onq[e] <= 1'b1;
          count  <= count + 5'd1;
        end
        if (do_deq) begin
          onq[e] <= 1'b0;
          count  <= count - 5'd1;
        end
        if (do_slice) begin
          if (op_kind == KIND_INIT || expire) slice[e] <= reload;
          else slice[e] <= slice[e] - op_run;
        end
      end
    end
  end

endmodule

// ----- design/strict_priority_round_robin_scheduler.sv -----
// Sequence: the edge that accepts a word starts analyze, then unlink, link and finish
// follow before its result word is offered.
// Flow: no new word is accepted until the result of the last one is taken and the
// sequencer is back in idle; a stalled result holds the sequencer. Reset (rst,
// synchronous): queues empty, levels and slices zero, slice reload back to 10 ms;
// link tables left as they are.
// ----------------------------------------------------------------------------
// strict_priority_round_robin_scheduler
// Strict priority scheduler with a round robin FIFO per level.
// ----------------------------------------------------------------------------
module strict_priority_round_robin_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [3:0]  entity,
  input  logic [7:0]  prio_level,
  input  logic [31:0] runtime_ns,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [3:0]  picked_entity,
  output logic [2:0]  picked_level,
  output logic        slice_expired,
  output logic [4:0]  queued_count
);
  import sprr_pkg::*;

  // The controller sequences the operation; the datapath owns the tables and results.
  sprr_cmd_t  cmd;
  sprr_stat_t stat;

  sprr_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .stat(stat), .cmd(cmd)
  );

  sprr_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .slice_we(cfg_we), .slice_wdata(cfg_wdata),
    .kind(kind), .entity(entity), .prio_level(prio_level), .runtime_ns(runtime_ns),
    .status(status), .picked_entity(picked_entity), .picked_level(picked_level),
    .slice_expired(slice_expired), .queued_count(queued_count)
  );

endmodule
